/* src/number_translation_chain_table_unit_defines.svh */
// assertion macros shared by the translation table rtl
// no dependencies; included by files that carry assertions
`ifndef NUMBER_TRANSLATION_CHAIN_TABLE_UNIT_DEFINES_SVH
`define NUMBER_TRANSLATION_CHAIN_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define NTCT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ntct assertion failed");

// next-cycle implication, checked outside reset
`define NTCT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ntct assertion failed");

`endif

/* src/ntct_pkg.sv */
// shared types, codes and sizes of the translation table unit
// no dependencies
package ntct_pkg;

   localparam int NUM_MAPS      = 4;
   localparam int TABLE_ENTRIES = 64;
   localparam int MAX_DIGITS    = 16;

   localparam int MAP_W = $clog2(NUM_MAPS);
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int MCN_W = $clog2(NUM_MAPS + 1);

   localparam logic [2:0] MODE_CREATE    = 3'd0;
   localparam logic [2:0] MODE_DELETE    = 3'd1;
   localparam logic [2:0] MODE_INSERT    = 3'd2;
   localparam logic [2:0] MODE_ERASE     = 3'd3;
   localparam logic [2:0] MODE_TRANSFORM = 3'd4;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_ID     = 3'd1;
   localparam logic [2:0] ST_BAD_NUMBER = 3'd2;
   localparam logic [2:0] ST_FULL       = 3'd3;
   localparam logic [2:0] ST_NO_IDS     = 3'd4;

   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  map_id;
      logic [63:0] src_digits;
      logic [4:0]  src_length;
      logic [63:0] dst_digits;
      logic [4:0]  dst_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  new_map_id;
      logic [63:0] result_digits;
      logic [4:0]  result_length;
      logic        cycle_found;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  map;
      logic [63:0] src;
      logic [4:0]  src_len;
      logic [63:0] tgt;
      logic [4:0]  tgt_len;
   } entry_type;

   typedef struct packed {
      logic        ok;
      logic [63:0] masked;
   } num_chk_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SEARCH = 3'b010,
      S_DONE   = 3'b100
   } state_type;

endpackage

/* src/ntct_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module ntct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* src/ntct_numchk.sv */
// checks a packed decimal number and clears the nibbles above its length
// depends on ntct_pkg
module ntct_numchk (
   input  logic [63:0]          digits,
   input  logic [4:0]           length,
   output ntct_pkg::num_chk_type chk
);
   import ntct_pkg::*;

   always_comb begin
      logic bad;
      bad = (length == 5'd0) || (length > 5'(MAX_DIGITS));
      chk.masked = '0;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < length) begin
            chk.masked[4*i +: 4] = digits[4*i +: 4];
            if (digits[4*i +: 4] > 4'd9) begin
               bad = 1'b1;
            end
         end
      end
      chk.ok = !bad;
   end

endmodule

/* src/number_translation_chain_table_unit.sv */
// Translation table unit: several numbered maps of packed decimal numbers in one
// shared entry ram. Each request creates or deletes a map, inserts or erases a
// mapping, or follows the chain of mappings from a number (transform).
// Channels: req_* carries one request (valid/ready), rsp_* one response per
// request (valid/ready). A request is taken only while the unit is idle.
// Create, delete of a dead map, unknown modes and rejected requests go from idle
// straight to the done state. Delete sweeps the entry ram once; insert and erase
// sweep it at most once and end early on a hit. Transform sweeps the ram once per
// number on its path, and TABLE_ENTRIES + 1 sweeps when a cycle is met. The sweep
// reads one entry per cycle through the single ram read port, which sets the rate.
// The next request can be taken in the cycle after the response register loads.
// Reset clears all entry valid bits, all maps and the id counter; the ram
// contents are left as they are. A stalled response stays in the output
// register; the unit may take and work on the next request meanwhile, and
// holds its finished response until the register frees.
// depends on ntct_pkg, ntct_ram, ntct_numchk and the defines header
`include "number_translation_chain_table_unit_defines.svh"

module number_translation_chain_table_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ntct_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ntct_pkg::rsp_type rsp_data
);
   import ntct_pkg::*;

   state_type state_ff, state_in;
   logic [2:0] mode_ff, mode_in;
   logic [1:0] id_ff, id_in;
   logic [63:0] key_d_ff, key_d_in, org_d_ff, org_d_in, dst_d_ff, dst_d_in;
   logic [4:0] key_l_ff, key_l_in, org_l_ff, org_l_in, dst_l_ff, dst_l_in;
   logic [CNT_W-1:0] iss_ff, iss_in, steps_ff, steps_in;
   logic chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in, fre_idx_ff, fre_idx_in;
   logic fre_fnd_ff, fre_fnd_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [NUM_MAPS-1:0] live_ff, live_in;
   logic [MCN_W-1:0] created_ff, created_in;
   rsp_type res_ff, res_in, rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   num_chk_type src_chk, dst_chk;
   entry_type rd_ent, wr_ent;
   logic rd_en, wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic vbit, hit_key, hit_map, last;

   ntct_numchk u_src_chk (
      .digits (req_data.src_digits),
      .length (req_data.src_length),
      .chk    (src_chk)
   );

   ntct_numchk u_dst_chk (
      .digits (req_data.dst_digits),
      .length (req_data.dst_length),
      .chk    (dst_chk)
   );

   ntct_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_ent),
      .rd_en   (rd_en),
      .rd_addr (iss_ff[IDX_W-1:0]),
      .rd_data (rd_ent)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign vbit    = valid_ff[chk_idx_ff];
   assign hit_map = vbit && (rd_ent.map == id_ff);
   assign hit_key = hit_map && (rd_ent.src_len == key_l_ff) && (rd_ent.src == key_d_ff);
   assign last    = (chk_idx_ff == IDX_W'(TABLE_ENTRIES - 1));

   assign wr_ent.map     = id_ff;
   assign wr_ent.src     = key_d_ff;
   assign wr_ent.src_len = key_l_ff;
   assign wr_ent.tgt     = dst_d_ff;
   assign wr_ent.tgt_len = dst_l_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      id_in        = id_ff;
      key_d_in     = key_d_ff;
      key_l_in     = key_l_ff;
      org_d_in     = org_d_ff;
      org_l_in     = org_l_ff;
      dst_d_in     = dst_d_ff;
      dst_l_in     = dst_l_ff;
      iss_in       = iss_ff;
      steps_in     = steps_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      fre_idx_in   = fre_idx_ff;
      fre_fnd_in   = fre_fnd_ff;
      valid_in     = valid_ff;
      live_in      = live_ff;
      created_in   = created_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = chk_idx_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in     = '0;
               mode_in    = req_data.mode;
               id_in      = req_data.map_id;
               key_d_in   = src_chk.masked;
               key_l_in   = req_data.src_length;
               org_d_in   = src_chk.masked;
               org_l_in   = req_data.src_length;
               dst_d_in   = dst_chk.masked;
               dst_l_in   = req_data.dst_length;
               iss_in     = '0;
               steps_in   = '0;
               fre_fnd_in = 1'b0;
               state_in   = S_DONE;
               priority if (req_data.mode == MODE_CREATE) begin
                  if (created_ff >= MCN_W'(NUM_MAPS)) begin
                     res_in.status = ST_NO_IDS;
                  end else begin
                     res_in.new_map_id = 2'(created_ff);
                     live_in[created_ff[MAP_W-1:0]] = 1'b1;
                     created_in = created_ff + 1'b1;
                  end
               end else if (req_data.mode == MODE_DELETE) begin
                  if (MCN_W'(req_data.map_id) >= created_ff) begin
                     res_in.status = ST_BAD_ID;
                  end else if (live_ff[req_data.map_id[MAP_W-1:0]]) begin
                     live_in[req_data.map_id[MAP_W-1:0]] = 1'b0;
                     state_in = S_SEARCH;
                  end
               end else if (req_data.mode == MODE_INSERT || req_data.mode == MODE_ERASE ||
                            req_data.mode == MODE_TRANSFORM) begin
                  if (MCN_W'(req_data.map_id) >= created_ff ||
                      !live_ff[req_data.map_id[MAP_W-1:0]]) begin
                     res_in.status = ST_BAD_ID;
                  end else if (!src_chk.ok) begin
                     res_in.status = ST_BAD_NUMBER;
                  end else if (req_data.mode == MODE_INSERT && !dst_chk.ok) begin
                     res_in.status = ST_BAD_NUMBER;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end else begin
                  // unknown modes answer ok with nothing else
                  state_in = S_DONE;
               end
            end
         end

         S_SEARCH: begin
            // issue reads in order; compare in the cycle after each read issues
            if (iss_ff < CNT_W'(TABLE_ENTRIES)) begin
               rd_en      = 1'b1;
               iss_in     = iss_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = iss_ff[IDX_W-1:0];
            end
            if (chk_vld_ff) begin
               if (mode_ff == MODE_DELETE) begin
                  if (hit_map) begin
                     valid_in[chk_idx_ff] = 1'b0;
                  end
                  if (last) begin
                     state_in = S_DONE;
                  end
               end else begin
                  if (!vbit && !fre_fnd_ff) begin
                     fre_fnd_in = 1'b1;
                     fre_idx_in = chk_idx_ff;
                  end
                  if (hit_key) begin
                     chk_vld_in = 1'b0;
                     iss_in     = '0;
                     state_in   = S_DONE;
                     if (mode_ff == MODE_INSERT) begin
                        wr_en = 1'b1;
                     end else if (mode_ff == MODE_ERASE) begin
                        valid_in[chk_idx_ff] = 1'b0;
                     end else if (steps_ff == CNT_W'(TABLE_ENTRIES)) begin
                        // more mappings than entries: the path repeats
                        res_in.cycle_found   = 1'b1;
                        res_in.result_digits = org_d_ff;
                        res_in.result_length = org_l_ff;
                     end else begin
                        key_d_in = rd_ent.tgt;
                        key_l_in = rd_ent.tgt_len;
                        steps_in = steps_ff + 1'b1;
                        state_in = S_SEARCH;
                     end
                  end else if (last) begin
                     state_in = S_DONE;
                     if (mode_ff == MODE_INSERT) begin
                        if (fre_fnd_ff || !vbit) begin
                           wr_en   = 1'b1;
                           wr_addr = fre_fnd_ff ? fre_idx_ff : chk_idx_ff;
                           valid_in[wr_addr] = 1'b1;
                        end else begin
                           res_in.status = ST_FULL;
                        end
                     end else if (mode_ff == MODE_TRANSFORM) begin
                        res_in.result_digits = key_d_ff;
                        res_in.result_length = key_l_ff;
                     end
                  end
               end
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         live_ff      <= '0;
         created_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         live_ff      <= live_in;
         created_ff   <= created_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      id_ff      <= id_in;
      key_d_ff   <= key_d_in;
      key_l_ff   <= key_l_in;
      org_d_ff   <= org_d_in;
      org_l_ff   <= org_l_in;
      dst_d_ff   <= dst_d_in;
      dst_l_ff   <= dst_l_in;
      iss_ff     <= iss_in;
      steps_ff   <= steps_in;
      chk_idx_ff <= chk_idx_in;
      fre_idx_ff <= fre_idx_in;
      fre_fnd_ff <= fre_fnd_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   `NTCT_ASSERT_IMP(a_chk_in_search, clock, reset, chk_vld_ff, state_ff == S_SEARCH)
   `NTCT_ASSERT_NXT(a_accept_busy, clock, reset, req_valid && req_ready, state_ff != S_IDLE)
   `NTCT_ASSERT_IMP(a_ids_bounded, clock, reset, 1'b1, created_ff <= MCN_W'(NUM_MAPS))
   `NTCT_ASSERT_IMP(a_write_in_search, clock, reset, wr_en, state_ff == S_SEARCH)
   `NTCT_ASSERT_IMP(a_cycle_has_number, clock, reset, rsp_valid_ff && rsp_ff.cycle_found,
      rsp_ff.result_length != 5'd0)

endmodule

/* tb/number_translation_chain_table_unit_tb.sv */
// testbench of the translation table unit: directed table, a fill of the store, then random requests
// checked against a behavioral copy of the maps and entry store
// depends on ntct_pkg and number_translation_chain_table_unit
module number_translation_chain_table_unit_tb;
   import ntct_pkg::*;

   // a mode the unit does not know
   localparam logic [2:0] MODE_UNKNOWN = 3'd7;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   number_translation_chain_table_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // behavioral copy of the store
   logic        ent_on [TABLE_ENTRIES];
   logic [1:0]  ent_map [TABLE_ENTRIES];
   logic [63:0] ent_src [TABLE_ENTRIES];
   logic [4:0]  ent_slen [TABLE_ENTRIES];
   logic [63:0] ent_tgt [TABLE_ENTRIES];
   logic [4:0]  ent_tlen [TABLE_ENTRIES];
   logic        live [NUM_MAPS];
   int          ids_issued;

   rsp_type pending_rsp[$];
   int      mismatches;
   logic    drain_done;

   function automatic logic [63:0] mask_of(input logic [4:0] len);
      if (len >= 16) return '1;
      return (64'd1 << (4 * len)) - 64'd1;
   endfunction

   function automatic logic digits_ok(input logic [63:0] d, input logic [4:0] len);
      if (len == 0 || len > MAX_DIGITS) return 0;
      for (int i = 0; i < len; i++)
         if (d[4*i +: 4] > 4'd9) return 0;
      return 1;
   endfunction

   function automatic int lookup(input logic [1:0] id, input logic [63:0] d,
                                 input logic [4:0] len);
      for (int e = 0; e < TABLE_ENTRIES; e++)
         if (ent_on[e] && ent_map[e] == id && ent_slen[e] == len && ent_src[e] == d)
            return e;
      return -1;
   endfunction

   function automatic rsp_type translate(input req_type r);
      rsp_type     o;
      int          e;
      int          n;
      logic        seen;
      logic [63:0] s;
      logic [63:0] t;
      logic [63:0] cd;
      logic [4:0]  cl;
      logic [63:0] pd [TABLE_ENTRIES + 1];
      logic [4:0]  pl [TABLE_ENTRIES + 1];
      o = '0;
      s = r.src_digits & mask_of(r.src_length);
      t = r.dst_digits & mask_of(r.dst_length);
      case (r.mode)
         MODE_CREATE: begin
            if (ids_issued >= NUM_MAPS) o.status = ST_NO_IDS;
            else begin
               o.new_map_id = 2'(ids_issued);
               live[ids_issued] = 1;
               ids_issued++;
            end
         end
         MODE_DELETE: begin
            if (r.map_id >= ids_issued) o.status = ST_BAD_ID;
            else if (live[r.map_id]) begin
               live[r.map_id] = 0;
               for (e = 0; e < TABLE_ENTRIES; e++)
                  if (ent_on[e] && ent_map[e] == r.map_id) ent_on[e] = 0;
            end
         end
         MODE_INSERT, MODE_ERASE, MODE_TRANSFORM: begin
            if (!(r.map_id < ids_issued && live[r.map_id])) o.status = ST_BAD_ID;
            else if (!digits_ok(r.src_digits, r.src_length)) o.status = ST_BAD_NUMBER;
            else if (r.mode == MODE_INSERT && !digits_ok(r.dst_digits, r.dst_length))
               o.status = ST_BAD_NUMBER;
            else begin
               e = lookup(r.map_id, s, r.src_length);
               if (r.mode == MODE_INSERT) begin
                  if (e < 0) begin
                     for (e = 0; e < TABLE_ENTRIES; e++)
                        if (!ent_on[e]) break;
                     if (e >= TABLE_ENTRIES) begin
                        o.status = ST_FULL;
                        e = -1;
                     end else begin
                        ent_on[e] = 1;
                        ent_map[e] = r.map_id;
                        ent_src[e] = s;
                        ent_slen[e] = r.src_length;
                     end
                  end
                  if (e >= 0) begin
                     ent_tgt[e] = t;
                     ent_tlen[e] = r.dst_length;
                  end
               end else if (r.mode == MODE_ERASE) begin
                  if (e >= 0) ent_on[e] = 0;
               end else begin
                  cd = s;
                  cl = r.src_length;
                  pd[0] = s;
                  pl[0] = cl;
                  n = 1;
                  while (e >= 0 && n <= TABLE_ENTRIES) begin
                     cd = ent_tgt[e];
                     cl = ent_tlen[e];
                     seen = 0;
                     for (int k = 0; k < n; k++)
                        if (pl[k] == cl && pd[k] == cd) seen = 1;
                     if (seen) begin
                        o.cycle_found = 1;
                        cd = s;
                        cl = r.src_length;
                        break;
                     end
                     pd[n] = cd;
                     pl[n] = cl;
                     n++;
                     e = lookup(r.map_id, cd, cl);
                  end
                  o.result_digits = cd;
                  o.result_length = cl;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic logic [63:0] rand_digits(input logic [4:0] len);
      logic [63:0] d;
      d = {$urandom, $urandom};
      for (int i = 0; i < 16; i++)
         if (i < len) d[4*i +: 4] = 4'($urandom_range(0, 9));
      return d;
   endfunction

   // mostly valid numbers from a small pool so chains and cycles form
   function automatic req_type rand_req();
      req_type r;
      int      p;
      r.mode = $urandom_range(0, 99) < 3 ? 3'($urandom_range(0, 7)) :
               3'($urandom_range(1, 4));
      if ($urandom_range(0, 20) == 0) r.mode = MODE_CREATE;
      r.map_id = 2'($urandom_range(0, 3));
      p = $urandom_range(0, 9);
      r.src_length = 5'($urandom_range(1, 2));
      r.src_digits = {$urandom, $urandom} & ~mask_of(r.src_length) | 64'(p % 10);
      r.dst_length = 5'($urandom_range(1, 2));
      r.dst_digits = 64'($urandom_range(0, 9));
      if (r.mode == MODE_INSERT && $urandom_range(0, 3) == 0)
         r.dst_digits = rand_digits(r.dst_length);
      if ($urandom_range(0, 19) == 0) begin
         r.src_length = 5'($urandom_range(0, 31));
         r.src_digits = {$urandom, $urandom};
      end
      if ($urandom_range(0, 19) == 0) begin
         r.dst_length = 5'($urandom_range(0, 31));
         r.dst_digits = {$urandom, $urandom};
      end
      if ($urandom_range(0, 9) == 0) begin
         r.src_length = 5'd16;
         r.src_digits = rand_digits(5'd16);
      end
      return r;
   endfunction

   function automatic int gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 150);
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 3);
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1000000000;
      $display("tb: failure");
      $finish;
   end

   // directed rows: request, typed expectation, whether to use it
   typedef struct {
      req_type r;
      rsp_type x;
      logic    fixed;
   } row_type;
   row_type rows [32];
   int      n_rows;

   function automatic req_type mk(input logic [2:0] m, input int id,
                                  input longint sd, input int sl,
                                  input longint dd, input int dl);
      req_type r;
      r.mode = m; r.map_id = 2'(id); r.src_digits = 64'(sd); r.src_length = 5'(sl);
      r.dst_digits = 64'(dd); r.dst_length = 5'(dl);
      return r;
   endfunction

   task automatic add(input req_type r, input rsp_type x, input logic fx);
      row_type w;
      w.r = r; w.x = x; w.fixed = fx;
      rows[n_rows] = w;
      n_rows++;
   endtask

   // valid stays high after acceptance; the caller drops it before a gap
   task automatic send(input req_type r, input logic fx, input rsp_type fx_rsp);
      rsp_type x;
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      x = translate(r);
      if (fx) x = fx_rsp;
      pending_rsp = {pending_rsp, x};
   endtask

   task automatic send_gap(input req_type r, input logic fx, input rsp_type fx_rsp);
      int g;
      g = gap();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      send(r, fx, fx_rsp);
   endtask

   // response side
   initial begin
      rsp_type x;
      rsp_ready = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h", rsp_data);
            end else begin
               x = pending_rsp.pop_front();
               if (rsp_data !== x) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %h got %h", x, rsp_data);
               end
            end
         end
         if ($urandom_range(0, 3) == 0 || drain_done) rsp_ready <= 1;
         else if ($urandom_range(0, 30) == 0) rsp_ready <= 0;
         else if ($urandom_range(0, 2) == 0) rsp_ready <= 1'($urandom_range(0, 1));
      end
   end

   initial begin
      rsp_type o;
      int      guard;
      mismatches = 0;
      drain_done = 0;
      n_rows = 0;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      for (int e = 0; e < TABLE_ENTRIES; e++) ent_on[e] = 0;
      for (int m = 0; m < NUM_MAPS; m++) live[m] = 0;
      ids_issued = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      o = '0;
      o.status = ST_BAD_ID;
      add(mk(MODE_TRANSFORM, 0, 1, 1, 0, 1), o, 1);
      add(mk(MODE_DELETE, 3, 0, 1, 0, 1), o, 1);
      o = '0;
      add(mk(MODE_CREATE, 2, 0, 0, 0, 0), o, 1);
      o.new_map_id = 1;
      add(mk(MODE_CREATE, 0, 0, 0, 0, 0), o, 1);
      o = '0;
      o.status = ST_BAD_NUMBER;
      add(mk(MODE_INSERT, 0, 1, 0, 2, 1), o, 1);
      add(mk(MODE_INSERT, 0, 1, 17, 2, 1), o, 1);
      add(mk(MODE_INSERT, 0, 64'hA, 1, 2, 1), o, 1);
      add(mk(MODE_INSERT, 0, 1, 1, 64'hF0, 2), o, 1);
      add(mk(MODE_INSERT, 0, 1, 1, 2, 31), o, 1);
      o = '0;
      add(mk(MODE_INSERT, 0, 64'hFFFF_FFFF_FFFF_FFF1, 1, 64'h99, 2), o, 1);
      add(mk(MODE_INSERT, 0, 64'h99, 2, 64'h9999_9999_9999_9999, 16), o, 1);
      add(mk(MODE_INSERT, 0, 64'h0, 16, 64'h01, 2), o, 1);
      add(mk(MODE_TRANSFORM, 0, 64'h1, 1, 0, 0), o, 0);
      add(mk(MODE_TRANSFORM, 0, 64'h01, 2, 0, 0), o, 0);
      add(mk(MODE_INSERT, 0, 64'h9999_9999_9999_9999, 16, 64'h1, 1), o, 1);
      add(mk(MODE_TRANSFORM, 0, 64'h99, 2, 0, 0), o, 0);
      add(mk(MODE_ERASE, 0, 64'h5, 1, 0, 0), o, 1);
      add(mk(MODE_ERASE, 0, 64'h1, 1, 0, 0), o, 1);
      add(mk(MODE_TRANSFORM, 0, 64'h99, 2, 0, 0), o, 0);
      add(mk(MODE_INSERT, 1, 64'h3, 1, 64'h3, 1), o, 1);
      add(mk(MODE_TRANSFORM, 1, 64'h3, 1, 0, 0), o, 0);
      add(mk(MODE_UNKNOWN, 1, 64'h3, 1, 0, 0), o, 1);
      add(mk(MODE_DELETE, 1, 0, 0, 0, 0), o, 1);
      add(mk(MODE_DELETE, 1, 0, 0, 0, 0), o, 1);
      o.status = ST_BAD_ID;
      add(mk(MODE_TRANSFORM, 1, 64'h3, 1, 0, 0), o, 1);

      // typed rows are checked as typed; the predictor still tracks the state
      for (int i = 0; i < n_rows; i++) send_gap(rows[i].r, rows[i].fixed, rows[i].x);

      // create until ids run out, then fill the store to reach the full case and erase the keys again
      o = '0;
      for (int m = 0; m < 3; m++) send_gap(mk(MODE_CREATE, 0, 0, 0, 0, 0), 0, o);
      for (int k = 0; k < 66; k++)
         send_gap(mk(MODE_INSERT, 2, 64'(k / 10 * 16 + k % 10), 2, 64'h7, 1), 0, o);
      for (int k = 0; k < 66; k++)
         send_gap(mk(MODE_ERASE, 2, 64'(k / 10 * 16 + k % 10), 2, 0, 0), 0, o);
      for (int k = 0; k < 1000; k++) send_gap(rand_req(), 0, o);
      req_valid <= 0;

      guard = 0;
      while (pending_rsp.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      drain_done = 1;
      repeat (200) @(posedge clock);
      if (pending_rsp.size() != 0) mismatches++;
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

/* filelist.f */
+incdir+src
src/ntct_pkg.sv
src/ntct_ram.sv
src/ntct_numchk.sv
src/number_translation_chain_table_unit.sv
tb/number_translation_chain_table_unit_tb.sv
